// ===== hdl/text_terminal_scroll_engine_top_defines.svh =====
// assertion macros for the text terminal scroll engine
// used by the top level only; expects clk and arst_n in scope
`ifndef TEXT_TERMINAL_SCROLL_ENGINE_TOP_DEFINES_SVH
`define TEXT_TERMINAL_SCROLL_ENGINE_TOP_DEFINES_SVH

// condition and consequence in the same cycle
`define TTSE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence in the cycle after the condition
`define TTSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ttse_pkg.sv =====
// shared constants, codes and controller/datapath link types
// for the text terminal scroll engine; no dependencies
package ttse_pkg;

	// screen geometry
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELLS      = ROWS * COLUMNS;
	localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;
	localparam int ADDR_W     = $clog2(CELLS);

	// item field widths
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CELL_W = 16;
	localparam int IN_W   = 24;
	localparam int OUT_W  = 32;

	// character and attribute codes
	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] SPACE_CODE   = 8'h20;
	localparam logic [7:0] RESET_COLOR  = 8'h07;

	// action codes
	localparam logic ACT_PUT  = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic put_write;    // put item accepted: store cell unless newline, move cursor
		logic read_issue;   // read item accepted: memory read issued
		logic sweep_step;   // advance the clear/scroll sweep by one cell
		logic sweep_clear;  // sweep fills every cell with the reset space
		logic res_load;     // capture read data as pending result
		logic out_load;     // load the output register
	} ttse_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic is_read;        // presented item is a read
		logic scroll_need;    // presented put moves below the bottom row
		logic sweep_last;     // sweep is at its last cell
		logic flush_pending;  // a delayed sweep write still has to land
		logic slot_free;      // output register can take a result
	} ttse_sts_t;

endpackage

// ===== hdl/text_terminal_scroll_engine_top.sv =====
// top level of the text terminal scroll engine
// depends on ttse_pkg, ttse_ctrl, ttse_datapath, text_terminal_scroll_engine_top_defines.svh
//
// channel | direction | handshake              | content
// s_*     | in        | s_tvalid / s_tready    | action, char_code, read_column, read_row
// m_*     | out       | m_tvalid / m_tready    | cell_entry, cursor_row, cursor_column
// cfg_*   | in        | cfg_wen                | text_color
//
// put without scroll: the result goes straight into the output register when it is free, and the next item can follow
// read: memory read, capture, then output load once the output register is free
// scroll: a sweep over every cell, one cell per cycle through the single memory write port
// after reset a clearing pass over every cell runs before the first item
// a full output register holds the result; the next item waits until it is taken
`include "text_terminal_scroll_engine_top_defines.svh"

module text_terminal_scroll_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // action, char_code, read_column, read_row
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // cell_entry, cursor_row, cursor_column
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata  // text_color
);

	ttse_pkg::ttse_cmd_t cmd;
	ttse_pkg::ttse_sts_t sts;

	// controller
	ttse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	ttse_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

	// checks
	`TTSE_ASSERT_NOW(a_cursor_range, m_tvalid, (m_tdata[20:16] <= 5'(ttse_pkg::ROWS - 1)) && (m_tdata[27:21] <= 7'(ttse_pkg::COLUMNS - 1)), "cursor outside the screen")
	`TTSE_ASSERT_NOW(a_no_write_clash, cmd.put_write, !sts.flush_pending, "put write collides with sweep write")
	`TTSE_ASSERT_NEXT(a_put_fast, s_tvalid && s_tready && !sts.is_read && !sts.scroll_need && sts.slot_free, m_tvalid, "plain put result not shown next cycle")

endmodule

// ===== hdl/ttse_ctrl.sv =====
// controller state machine: reset clear, put/read handling, scroll sweep
// depends on ttse_pkg
module ttse_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  ttse_pkg::ttse_sts_t  sts,
	output ttse_pkg::ttse_cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_READ   = 5'b00100,
		ST_SCROLL = 5'b01000,
		ST_WAIT   = 5'b10000
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        accept;

	assign s_tready = (state_q == ST_IDLE) && !sts.flush_pending;
	assign accept   = s_tvalid && s_tready;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.sweep_step  = 1'b1;
				cmd.sweep_clear = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (sts.is_read) begin
						cmd.read_issue = 1'b1;
						state_d        = ST_READ;
					end else begin
						cmd.put_write = 1'b1;
						if (sts.scroll_need) begin
							state_d = ST_SCROLL;
						end else if (sts.slot_free) begin
							cmd.out_load = 1'b1;
						end else begin
							state_d = ST_WAIT;
						end
					end
				end
			end
			ST_READ: begin
				cmd.res_load = 1'b1;
				state_d      = ST_WAIT;
			end
			ST_SCROLL: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (sts.slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/ttse_datapath.sv =====
// datapath: screen memory, cursor, color register, sweep pipeline, output register
// depends on ttse_pkg
module ttse_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ttse_pkg::IN_W-1:0]     s_tdata,
	input  logic                          cfg_wen,
	input  logic [7:0]                    cfg_wdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ttse_pkg::OUT_W-1:0]    m_tdata,
	input  ttse_pkg::ttse_cmd_t           cmd,
	output ttse_pkg::ttse_sts_t           sts
);

	localparam int AW = ttse_pkg::ADDR_W;

	// input item fields
	logic                       in_action;
	logic [7:0]                 in_char;
	logic [ttse_pkg::COL_W-1:0] in_rcol;
	logic [ttse_pkg::ROW_W-1:0] in_rrow;

	assign in_action = s_tdata[0];
	assign in_char   = s_tdata[8:1];
	assign in_rcol   = s_tdata[15:9];
	assign in_rrow   = s_tdata[20:16];

	// state registers
	logic [7:0]                  text_color_q;
	logic [ttse_pkg::ROW_W-1:0]  cur_row_q;
	logic [ttse_pkg::COL_W-1:0]  cur_col_q;
	logic [AW-1:0]               sweep_idx_q;
	logic                        in_range_q;
	logic [ttse_pkg::CELL_W-1:0] res_cell_q;
	logic [ttse_pkg::CELL_W-1:0] rd_data_q;
	logic                        out_valid_q;
	logic [ttse_pkg::CELL_W-1:0] out_cell_q;
	logic [ttse_pkg::ROW_W-1:0]  out_row_q;
	logic [ttse_pkg::COL_W-1:0]  out_col_q;

	// delayed sweep write
	logic          wr_en_s1;
	logic [AW-1:0] wr_addr_s1;
	logic          fill_s1;
	logic [7:0]    attr_s1;

	logic [ttse_pkg::CELL_W-1:0] screen_mem [ttse_pkg::CELLS];

	// cursor movement for a put
	logic                       is_nl;
	logic                       wrap;
	logic                       at_bottom;
	logic [ttse_pkg::ROW_W-1:0] row_put;
	logic [ttse_pkg::COL_W-1:0] col_put;
	logic [ttse_pkg::ROW_W-1:0] row_next;
	logic [ttse_pkg::COL_W-1:0] col_next;

	assign is_nl     = (in_char == ttse_pkg::NEWLINE_CODE);
	assign wrap      = is_nl || (cur_col_q == ttse_pkg::COL_W'(ttse_pkg::COLUMNS - 1));
	assign at_bottom = (cur_row_q == ttse_pkg::ROW_W'(ttse_pkg::ROWS - 1));
	assign row_put   = (wrap && !at_bottom) ? cur_row_q + 1'b1 : cur_row_q;
	assign col_put   = wrap ? '0 : cur_col_q + 1'b1;
	assign row_next  = cmd.put_write ? row_put : cur_row_q;
	assign col_next  = cmd.put_write ? col_put : cur_col_q;

	// addresses
	logic [AW-1:0] put_addr;
	logic [AW-1:0] rd_addr;
	logic          rd_in_range;
	logic [AW-1:0] sweep_raddr;
	logic          sweep_fill;

	assign put_addr = AW'(AW'(cur_row_q) * AW'(ttse_pkg::COLUMNS) + AW'(cur_col_q));
	assign rd_addr  = AW'(AW'(in_rrow) * AW'(ttse_pkg::COLUMNS) + AW'(in_rcol));
	assign rd_in_range = (32'(in_rcol) < ttse_pkg::COLUMNS) && (32'(in_rrow) < ttse_pkg::ROWS);
	assign sweep_raddr = AW'(sweep_idx_q + AW'(ttse_pkg::COLUMNS));
	assign sweep_fill  = cmd.sweep_clear || (32'(sweep_idx_q) >= ttse_pkg::COPY_CELLS);

	// memory port selection
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [ttse_pkg::CELL_W-1:0] mem_wdata;
	logic [AW-1:0]               mem_raddr;

	assign mem_we    = wr_en_s1 || (cmd.put_write && !is_nl);
	assign mem_waddr = wr_en_s1 ? wr_addr_s1 : put_addr;
	assign mem_wdata = wr_en_s1 ? (fill_s1 ? {attr_s1, ttse_pkg::SPACE_CODE} : rd_data_q)
	                            : {text_color_q, in_char};
	assign mem_raddr = cmd.sweep_step ? sweep_raddr : rd_addr;

	// screen memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			screen_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= screen_mem[mem_raddr];
	end

	// sweep write stage payload
	always_ff @(posedge clk) begin
		wr_addr_s1 <= sweep_idx_q;
		fill_s1    <= sweep_fill;
		attr_s1    <= cmd.sweep_clear ? ttse_pkg::RESET_COLOR : text_color_q;
	end

	// control state: color, cursor, sweep counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= ttse_pkg::RESET_COLOR;
			cur_row_q    <= '0;
			cur_col_q    <= '0;
			sweep_idx_q  <= '0;
			wr_en_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				text_color_q <= cfg_wdata;
			end
			cur_row_q <= row_next;
			cur_col_q <= col_next;
			wr_en_s1  <= cmd.sweep_step;
			if (cmd.sweep_step) begin
				sweep_idx_q <= sts.sweep_last ? '0 : sweep_idx_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// pending result and output payload
	always_ff @(posedge clk) begin
		if (cmd.read_issue) begin
			in_range_q <= rd_in_range;
		end
		if (cmd.put_write) begin
			res_cell_q <= '0;
		end else if (cmd.res_load) begin
			res_cell_q <= in_range_q ? rd_data_q : '0;
		end
		if (cmd.out_load) begin
			out_cell_q <= cmd.put_write ? '0 : res_cell_q;
			out_row_q  <= row_next;
			out_col_q  <= col_next;
		end
	end

	// status
	assign sts.is_read       = (in_action == ttse_pkg::ACT_READ);
	assign sts.scroll_need   = wrap && at_bottom;
	assign sts.sweep_last    = (sweep_idx_q == AW'(ttse_pkg::CELLS - 1));
	assign sts.flush_pending = wr_en_s1;
	assign sts.slot_free     = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_col_q, out_row_q, out_cell_q};

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// self-checking bench for the text terminal scroll engine top level
// depends on ttse_pkg and text_terminal_scroll_engine_top; predicts every result in line
module testbench;
	import ttse_pkg::*;

	// item layouts, last declared field in the lowest bits
	typedef struct packed {
		logic [ROW_W-1:0] read_row;
		logic [COL_W-1:0] read_column;
		logic [7:0]       char_code;
		logic             action;
	} term_item_t;

	typedef struct packed {
		logic [COL_W-1:0]  cursor_column;
		logic [ROW_W-1:0]  cursor_row;
		logic [CELL_W-1:0] cell_entry;
	} term_result_t;

	localparam int SETTLE_CYCLES = CELLS + 64;
	localparam longint CYCLE_LIMIT = 4000000;
	localparam int IDLE_PCT = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AT_RESULT = 300;
	localparam int ITEMS_PER_PHASE = 190;
	localparam int MAX_REPORTS = 25;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;   // action, char_code, read_column, read_row
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;        // cell_entry, cursor_row, cursor_column
	logic             cfg_wen = 1'b0;
	logic [7:0]       cfg_wdata = '0; // text_color

	// screen shadow and cursor
	logic [CELL_W-1:0] screen_shadow [CELLS];
	int                cur_row;
	int                cur_col;
	logic [7:0]        shadow_color;

	term_item_t   pending_items [$];
	term_result_t expected_results [$];

	int     err_count = 0;
	int     items_sent = 0;
	int     results_seen = 0;
	int     put_count = 0;
	int     read_count = 0;
	int     outside_reads = 0;
	int     scroll_count = 0;
	int     wrap_count = 0;
	int     color_writes = 0;
	longint cycle_count = 0;
	logic   in_taken = 1'b0;
	int     hold_left = 0;
	logic   hold_done = 1'b0;

	text_terminal_scroll_engine_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// cursor to the start of the next row, scrolling at the bottom
	function automatic void next_line();
		cur_col = 0;
		cur_row++;
		if (cur_row >= ROWS) begin
			cur_row = ROWS - 1;
			scroll_count++;
			for (int i = 0; i < COPY_CELLS; i++)
				screen_shadow[i] = screen_shadow[i + COLUMNS];
			for (int i = 0; i < COLUMNS; i++)
				screen_shadow[COPY_CELLS + i] = {shadow_color, SPACE_CODE};
		end
	endfunction

	// expected result of one item, updating the shadow screen
	function automatic term_result_t terminal_step(term_item_t it);
		term_result_t res;
		res.cell_entry = '0;
		if (it.action == ACT_PUT) begin
			put_count++;
			if (it.char_code == NEWLINE_CODE) begin
				next_line();
			end else begin
				screen_shadow[cur_row * COLUMNS + cur_col] = {shadow_color, it.char_code};
				cur_col++;
				if (cur_col >= COLUMNS) begin
					wrap_count++;
					next_line();
				end
			end
		end else begin
			read_count++;
			if (it.read_column < COLUMNS && it.read_row < ROWS)
				res.cell_entry = screen_shadow[it.read_row * COLUMNS + it.read_column];
			else
				outside_reads++;
		end
		res.cursor_row = cur_row[ROW_W-1:0];
		res.cursor_column = cur_col[COL_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (err_count < MAX_REPORTS)
			$display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
				results_seen, what, got, want);
		err_count++;
	endtask

	// item builders; unused fields carry random bits
	function automatic term_item_t put_item(logic [7:0] ch);
		term_item_t it;
		it = term_item_t'($urandom);
		it.action = ACT_PUT;
		it.char_code = ch;
		return it;
	endfunction

	function automatic term_item_t read_item(int col, int row);
		term_item_t it;
		it = term_item_t'($urandom);
		it.action = ACT_READ;
		it.read_column = col[COL_W-1:0];
		it.read_row = row[ROW_W-1:0];
		return it;
	endfunction

	// a read, mostly on the screen, often on the bottom row, sometimes anywhere in the field ranges
	function automatic term_item_t some_read();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return read_item($urandom_range(0, COLUMNS - 1), $urandom_range(0, ROWS - 1));
		else if (pick < 80)
			return read_item($urandom_range(0, COLUMNS - 1), ROWS - 1);
		else
			return read_item($urandom_range(0, 127), $urandom_range(0, 31));
	endfunction

	// mostly text lines ending in a newline with reads mixed in, some long enough to wrap
	task automatic queue_random_items(int count);
		int queued;
		int len;
		int pick;
		queued = 0;
		while (queued < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 82) begin
				pick = $urandom_range(0, 99);
				if (pick < 60)
					len = $urandom_range(0, 4);
				else if (pick < 88)
					len = $urandom_range(5, 30);
				else
					len = $urandom_range(COLUMNS - 2, COLUMNS + 4);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 99) < 25) begin
						pending_items.push_back(some_read());
						queued++;
					end
					pending_items.push_back(put_item($urandom_range(32, 126)));
					queued++;
				end
				pending_items.push_back(put_item(NEWLINE_CODE));
				queued++;
			end else begin
				pending_items.push_back(term_item_t'($urandom));
				queued++;
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// attribute write once the engine has gone quiet, scroll included
	task automatic write_text_color(logic [7:0] color);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= color;
		shadow_color = color;
		color_writes++;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// sender: next item from the pending queue, with random gaps
	always @(negedge clk) begin
		logic quiet;
		quiet = items_sent >= 300 && items_sent < 450;
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (pending_items.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
				s_tvalid <= 1'b1;
				s_tdata <= {{(IN_W - $bits(term_item_t)){1'b0}}, pending_items.pop_front()};
				items_sent++;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, once, so the engine backs up into its input
	always @(negedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
		else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// receiver: random stalls outside the quiet window
	always @(negedge clk) begin
		logic quiet;
		quiet = results_seen >= 600 && results_seen < 750;
		m_tready <= arst_n && hold_left == 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT);
	end

	// check results, then predict accepted items
	always @(posedge clk) begin
		term_result_t got;
		term_result_t want;
		in_taken = arst_n && s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			got = term_result_t'(m_tdata[$bits(term_result_t)-1:0]);
			if (expected_results.size() == 0) begin
				report_mismatch("result with no item outstanding", got, 0);
			end else begin
				want = expected_results.pop_front();
				if (got.cell_entry !== want.cell_entry)
					report_mismatch("cell_entry", got.cell_entry, want.cell_entry);
				if (got.cursor_row !== want.cursor_row)
					report_mismatch("cursor_row", got.cursor_row, want.cursor_row);
				if (got.cursor_column !== want.cursor_column)
					report_mismatch("cursor_column", got.cursor_column, want.cursor_column);
			end
			results_seen++;
		end
		if (in_taken)
			expected_results.push_back(terminal_step(term_item_t'(s_tdata[$bits(term_item_t)-1:0])));
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_results.size());
			$display("text_terminal_scroll_engine_top regression: fail");
			$finish;
		end
	end

	initial begin
		logic [7:0] phase_colors [5];
		phase_colors[0] = 8'h00;
		phase_colors[1] = 8'hFF;
		phase_colors[2] = 8'h5A;
		phase_colors[3] = 8'hA5;
		phase_colors[4] = $urandom_range(0, 255);

		// shadow state after reset
		for (int i = 0; i < CELLS; i++)
			screen_shadow[i] = {RESET_COLOR, SPACE_CODE};
		cur_row = 0;
		cur_col = 0;
		shadow_color = RESET_COLOR;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset contents, character extremes, reads off the screen, newlines
		pending_items.push_back(read_item(0, 0));
		pending_items.push_back(read_item(COLUMNS - 1, ROWS - 1));
		pending_items.push_back(put_item(8'h00));
		pending_items.push_back(put_item(8'hFF));
		pending_items.push_back(put_item(8'h41));
		pending_items.push_back(read_item(0, 0));
		pending_items.push_back(read_item(1, 0));
		pending_items.push_back(read_item(2, 0));
		pending_items.push_back(read_item(3, 0));
		pending_items.push_back(read_item(COLUMNS, 0));
		pending_items.push_back(read_item(0, ROWS));
		pending_items.push_back(read_item(127, 31));
		pending_items.push_back(put_item(NEWLINE_CODE));
		pending_items.push_back(put_item(NEWLINE_CODE));
		pending_items.push_back(put_item(SPACE_CODE));
		pending_items.push_back(read_item(0, 2));
		pending_items.push_back(read_item(0, 1));

		// random phases, one attribute each
		for (int p = 0; p < 5; p++) begin
			write_text_color(phase_colors[p]);
			queue_random_items(ITEMS_PER_PHASE);
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results never delivered", expected_results.size(), 0);

		$display("covered %0d puts with %0d scrolls and %0d line wraps, %0d reads (%0d off screen)",
			put_count, scroll_count, wrap_count, read_count, outside_reads);
		$display("%0d attribute writes, %0d results checked, %0d mismatches",
			color_writes, results_seen, err_count);
		if (err_count == 0)
			$display("text_terminal_scroll_engine_top regression: pass");
		else
			$display("text_terminal_scroll_engine_top regression: fail");
		$finish;
	end

endmodule
